/* rtl/core/ltl_lex_pkg.sv */
// Shared types, character codes and token codes for the LTL token lexer.
// No dependencies; used by every module of the lexer.
package ltl_lex_pkg;

  localparam int NRES = 3;  // most results one character can cause

  typedef enum logic [3:0] {
    TK_NEG   = 4'd0,
    TK_IMPL  = 4'd1,
    TK_EQU   = 4'd2,
    TK_EVE   = 4'd3,
    TK_AND   = 4'd4,
    TK_OR    = 4'd5,
    TK_ALW   = 4'd6,
    TK_UNTIL = 4'd7,
    TK_REL   = 4'd8,
    TK_NEXT  = 4'd9,
    TK_LPAR  = 4'd10,
    TK_RPAR  = 4'd11,
    TK_ID    = 4'd12,
    TK_END   = 4'd13,
    TK_ERR   = 4'd14
  } tok_t;

  typedef enum logic [7:0] {
    M_IDLE   = 8'b0000_0001,
    M_DASH   = 8'b0000_0010,
    M_LT     = 8'b0000_0100,
    M_LTDASH = 8'b0000_1000,
    M_AMP    = 8'b0001_0000,
    M_BAR    = 8'b0010_0000,
    M_LBRK   = 8'b0100_0000,
    M_ID     = 8'b1000_0000
  } mode_t;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_AMP    = 8'h26;
  localparam logic [7:0] CH_LPAR   = 8'h28;
  localparam logic [7:0] CH_RPAR   = 8'h29;
  localparam logic [7:0] CH_DASH   = 8'h2D;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_U      = 8'h55;
  localparam logic [7:0] CH_V      = 8'h56;
  localparam logic [7:0] CH_X      = 8'h58;
  localparam logic [7:0] CH_LBRK   = 8'h5B;
  localparam logic [7:0] CH_RBRK   = 8'h5D;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_BAR    = 8'h7C;
  localparam logic [7:0] CH_RBRACE = 8'h7D;

  typedef struct packed {
    tok_t       token;
    logic [7:0] id_char;
    logic       id_end;
    logic       last;
  } res_t;

  // Results of one character plus the mode it leaves behind.
  typedef struct packed {
    res_t [NRES-1:0] res;
    logic [1:0]      cnt;
    mode_t           next_mode;
  } bundle_t;

  function automatic res_t mk_res(tok_t t, logic [7:0] c, logic e);
    res_t r;
    r.token   = t;
    r.id_char = c;
    r.id_end  = e;
    r.last    = 1'b0;
    return r;
  endfunction

endpackage

/* rtl/core/ltl_lex_decode.sv */
// Decodes one character against the current lexer mode into up to three results.
// Depends on ltl_lex_pkg.
module ltl_lex_decode (
  input  ltl_lex_pkg::mode_t   mode,
  input  logic [7:0]           ch,
  output ltl_lex_pkg::bundle_t bundle
);

  logic               idle_has;
  ltl_lex_pkg::res_t  idle_res;
  ltl_lex_pkg::mode_t idle_mode;

  // character seen from idle
  always_comb begin
    idle_has  = 1'b1;
    idle_res  = ltl_lex_pkg::mk_res(ltl_lex_pkg::TK_ERR, 8'h00, 1'b0);
    idle_mode = ltl_lex_pkg::M_IDLE;
    case (ch)
      ltl_lex_pkg::CH_BANG: idle_res = ltl_lex_pkg::mk_res(ltl_lex_pkg::TK_NEG, 8'h00, 1'b0);
      ltl_lex_pkg::CH_U:    idle_res = ltl_lex_pkg::mk_res(ltl_lex_pkg::TK_UNTIL, 8'h00, 1'b0);
      ltl_lex_pkg::CH_V:    idle_res = ltl_lex_pkg::mk_res(ltl_lex_pkg::TK_REL, 8'h00, 1'b0);
      ltl_lex_pkg::CH_X:    idle_res = ltl_lex_pkg::mk_res(ltl_lex_pkg::TK_NEXT, 8'h00, 1'b0);
      ltl_lex_pkg::CH_LPAR: idle_res = ltl_lex_pkg::mk_res(ltl_lex_pkg::TK_LPAR, 8'h00, 1'b0);
      ltl_lex_pkg::CH_RPAR: idle_res = ltl_lex_pkg::mk_res(ltl_lex_pkg::TK_RPAR, 8'h00, 1'b0);
      ltl_lex_pkg::CH_NUL,
      ltl_lex_pkg::CH_HASH: idle_res = ltl_lex_pkg::mk_res(ltl_lex_pkg::TK_END, 8'h00, 1'b0);
      ltl_lex_pkg::CH_LBRACE: begin
        idle_res  = ltl_lex_pkg::mk_res(ltl_lex_pkg::TK_ID, ch, 1'b0);
        idle_mode = ltl_lex_pkg::M_ID;
      end
      ltl_lex_pkg::CH_DASH: begin
        idle_has  = 1'b0;
        idle_mode = ltl_lex_pkg::M_DASH;
      end
      ltl_lex_pkg::CH_LT: begin
        idle_has  = 1'b0;
        idle_mode = ltl_lex_pkg::M_LT;
      end
      ltl_lex_pkg::CH_AMP: begin
        idle_has  = 1'b0;
        idle_mode = ltl_lex_pkg::M_AMP;
      end
      ltl_lex_pkg::CH_BAR: begin
        idle_has  = 1'b0;
        idle_mode = ltl_lex_pkg::M_BAR;
      end
      ltl_lex_pkg::CH_LBRK: begin
        idle_has  = 1'b0;
        idle_mode = ltl_lex_pkg::M_LBRK;
      end
      default: idle_has = 1'b1;
    endcase
  end

  always_comb begin
    logic [1:0]         k;
    logic [1:0]         errs;
    ltl_lex_pkg::res_t  ents [ltl_lex_pkg::NRES];
    ltl_lex_pkg::mode_t nm;
    ltl_lex_pkg::res_t  err_res;
    err_res = ltl_lex_pkg::mk_res(ltl_lex_pkg::TK_ERR, 8'h00, 1'b0);
    for (int i = 0; i < ltl_lex_pkg::NRES; i++) ents[i] = '0;
    k    = 2'd0;
    errs = 2'd0;
    nm   = mode;
    case (mode)
      ltl_lex_pkg::M_IDLE: begin
        if (idle_has) begin
          ents[0] = idle_res;
          k       = 2'd1;
        end
        nm = idle_mode;
      end
      ltl_lex_pkg::M_DASH: begin
        if (ch == ltl_lex_pkg::CH_GT) begin
          ents[0] = ltl_lex_pkg::mk_res(ltl_lex_pkg::TK_IMPL, 8'h00, 1'b0);
          k       = 2'd1;
          nm      = ltl_lex_pkg::M_IDLE;
        end else errs = 2'd1;
      end
      ltl_lex_pkg::M_LT: begin
        if (ch == ltl_lex_pkg::CH_GT) begin
          ents[0] = ltl_lex_pkg::mk_res(ltl_lex_pkg::TK_EVE, 8'h00, 1'b0);
          k       = 2'd1;
          nm      = ltl_lex_pkg::M_IDLE;
        end else if (ch == ltl_lex_pkg::CH_DASH) begin
          nm = ltl_lex_pkg::M_LTDASH;
        end else errs = 2'd1;
      end
      ltl_lex_pkg::M_LTDASH: begin
        if (ch == ltl_lex_pkg::CH_GT) begin
          ents[0] = ltl_lex_pkg::mk_res(ltl_lex_pkg::TK_EQU, 8'h00, 1'b0);
          k       = 2'd1;
          nm      = ltl_lex_pkg::M_IDLE;
        end else errs = 2'd2;
      end
      ltl_lex_pkg::M_AMP: begin
        if (ch == ltl_lex_pkg::CH_AMP) begin
          ents[0] = ltl_lex_pkg::mk_res(ltl_lex_pkg::TK_AND, 8'h00, 1'b0);
          k       = 2'd1;
          nm      = ltl_lex_pkg::M_IDLE;
        end else errs = 2'd1;
      end
      ltl_lex_pkg::M_BAR: begin
        if (ch == ltl_lex_pkg::CH_BAR) begin
          ents[0] = ltl_lex_pkg::mk_res(ltl_lex_pkg::TK_OR, 8'h00, 1'b0);
          k       = 2'd1;
          nm      = ltl_lex_pkg::M_IDLE;
        end else errs = 2'd1;
      end
      ltl_lex_pkg::M_LBRK: begin
        if (ch == ltl_lex_pkg::CH_RBRK) begin
          ents[0] = ltl_lex_pkg::mk_res(ltl_lex_pkg::TK_ALW, 8'h00, 1'b0);
          k       = 2'd1;
          nm      = ltl_lex_pkg::M_IDLE;
        end else errs = 2'd1;
      end
      ltl_lex_pkg::M_ID: begin
        ents[0] = ltl_lex_pkg::mk_res(ltl_lex_pkg::TK_ID, ch, ch == ltl_lex_pkg::CH_RBRACE);
        k       = 2'd1;
        nm      = (ch == ltl_lex_pkg::CH_RBRACE) ? ltl_lex_pkg::M_IDLE : ltl_lex_pkg::M_ID;
      end
      default: nm = ltl_lex_pkg::M_IDLE;
    endcase

    // broken prefix: one error per pending char, then relex from idle
    if (errs != 2'd0) begin
      ents[0] = err_res;
      if (errs == 2'd2) ents[1] = err_res;
      k = errs;
      if (idle_has) begin
        ents[k] = idle_res;
        k       = k + 2'd1;
      end
      nm = idle_mode;
    end

    for (int i = 0; i < ltl_lex_pkg::NRES; i++) begin
      ents[i].last    = (k != 2'd0) && (2'(i) == k - 2'd1);
      bundle.res[i]   = ents[i];
    end
    bundle.cnt       = k;
    bundle.next_mode = nm;
  end

endmodule

/* rtl/core/ltl_lex_emit.sv */
// Result buffer: holds the results of one character and hands them out one beat at a time.
// Depends on ltl_lex_pkg.
module ltl_lex_emit (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 load,
  input  ltl_lex_pkg::bundle_t bundle,
  output logic                 free,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output ltl_lex_pkg::res_t    out_res
);

  ltl_lex_pkg::res_t [ltl_lex_pkg::NRES-1:0] buf_r;
  logic [1:0] cnt_r, cnt_nxt;
  logic [1:0] idx_r, idx_nxt;
  logic       take, done;

  assign out_tvalid = (cnt_r != 2'd0);
  assign out_res    = buf_r[idx_r];
  assign take       = out_tvalid && out_tready;
  assign done       = take && (idx_r == cnt_r - 2'd1);
  assign free       = (cnt_r == 2'd0) || done;

  always_comb begin
    cnt_nxt = cnt_r;
    idx_nxt = idx_r;
    if (load) begin
      cnt_nxt = bundle.cnt;
      idx_nxt = 2'd0;
    end else if (done) begin
      cnt_nxt = 2'd0;
      idx_nxt = 2'd0;
    end else if (take) begin
      idx_nxt = idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
      idx_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
      idx_r <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) buf_r <= bundle.res;
  end

endmodule

/* rtl/core/ltl_token_lexer.sv */
// LTL token lexer top level: input register, mode register, decode and result buffer.
// A character goes from the input register through decode into the result buffer.
// Throughput: one character per cycle while each gives at most one result and the output
// is not stalled; a character with more results holds the input until its last one is taken.
// Reset (rst_n low, synchronous): mode returns to idle, input and result stages empty.
// Depends on ltl_lex_pkg, ltl_lex_decode and ltl_lex_emit.
module ltl_token_lexer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] ch
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [3:0] token, [11:4] id_char, [15:12] zero
  output logic        out_tuser,  // [0] id_end
  output logic        out_tlast
);

  logic                 s1_valid_r;
  logic [7:0]           ch_r;
  ltl_lex_pkg::mode_t   mode_r;
  ltl_lex_pkg::bundle_t bundle;
  ltl_lex_pkg::res_t    out_res;
  logic                 emit_free;
  logic                 s1_adv;
  logic                 emit_load;

  ltl_lex_decode u_decode (
    .mode   (mode_r),
    .ch     (ch_r),
    .bundle (bundle)
  );

  assign s1_adv    = s1_valid_r && ((bundle.cnt == 2'd0) || emit_free);
  assign emit_load = s1_adv && (bundle.cnt != 2'd0);
  assign in_tready = !s1_valid_r || s1_adv;

  ltl_lex_emit u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (emit_load),
    .bundle     (bundle),
    .free       (emit_free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_res    (out_res)
  );

  assign out_tdata = {4'b0000, out_res.id_char, out_res.token};
  assign out_tuser = out_res.id_end;
  assign out_tlast = out_res.last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      mode_r     <= ltl_lex_pkg::M_IDLE;
    end else begin
      if (in_tready) s1_valid_r <= in_tvalid;
      if (s1_adv) mode_r <= bundle.next_mode;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) ch_r <= in_tdata;
  end

  // mode only moves when a character leaves the input stage
  a_mode_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_adv |=> $stable(mode_r))
    else $error("lexer mode changed without a character");

  // a character beat always lands in the input stage
  a_in_lands: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> s1_valid_r)
    else $error("accepted character lost");

  // results of one character come out without a gap
  a_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast |=> out_tvalid)
    else $error("result run broken before its last beat");

endmodule

/* verif/tb_ltl_token_lexer.sv */
// Self-checking testbench for ltl_token_lexer: streams formula characters in bursts,
// predicts the token beats in-line and checks every output beat field by field.
// Depends on ltl_lex_pkg and the ltl_token_lexer RTL.
module tb_ltl_token_lexer;

  localparam int NDIR         = 32;
  localparam int N_RANDOM     = 400;
  localparam int DRAIN_MARK   = -1;
  localparam int HOLD_AT      = 80;
  localparam int HOLD_LEN     = 150;
  localparam int TAIL_CYCLES  = 20;
  localparam int LIMIT_CYCLES = 200000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic        out_tuser;
  logic        out_tlast;

  ltl_token_lexer u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  logic [7:0] dir_chars [NDIR] = '{
    ltl_lex_pkg::CH_BANG, ltl_lex_pkg::CH_U, ltl_lex_pkg::CH_V, ltl_lex_pkg::CH_X,
    ltl_lex_pkg::CH_LPAR, ltl_lex_pkg::CH_RPAR,
    ltl_lex_pkg::CH_DASH, ltl_lex_pkg::CH_GT, ltl_lex_pkg::CH_LT, ltl_lex_pkg::CH_DASH,
    ltl_lex_pkg::CH_GT, ltl_lex_pkg::CH_LT, ltl_lex_pkg::CH_GT,
    ltl_lex_pkg::CH_AMP, ltl_lex_pkg::CH_AMP, ltl_lex_pkg::CH_BAR, ltl_lex_pkg::CH_BAR,
    ltl_lex_pkg::CH_LBRK, ltl_lex_pkg::CH_RBRK,
    ltl_lex_pkg::CH_LBRACE, ltl_lex_pkg::CH_NUL, ltl_lex_pkg::CH_HASH,
    ltl_lex_pkg::CH_RBRACE,
    ltl_lex_pkg::CH_RBRACE, 8'hFF,
    ltl_lex_pkg::CH_LT, ltl_lex_pkg::CH_DASH, ltl_lex_pkg::CH_LBRACE,
    ltl_lex_pkg::CH_RBRACE,
    ltl_lex_pkg::CH_DASH, ltl_lex_pkg::CH_HASH, ltl_lex_pkg::CH_NUL
  };

  int                 char_q[$];
  ltl_lex_pkg::res_t  tok_expect_q[$];
  ltl_lex_pkg::res_t  char_res[$];
  ltl_lex_pkg::mode_t lex_state = ltl_lex_pkg::M_IDLE;

  int n_chars = 0;
  int chars_accepted = 0;
  int beats_seen = 0;
  int err_cnt = 0;
  int burst_left = 1;
  int gap_left = 0;
  int rx_cycle = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
  end

  initial begin
    #(LIMIT_CYCLES * 4);
    $display("CHECK FAILED");
    $finish;
  end

  // ---------------- token prediction ----------------
  task automatic emit_tok(input ltl_lex_pkg::tok_t t, input logic [7:0] c, input logic e);
    ltl_lex_pkg::res_t r;
    r.token   = t;
    r.id_char = c;
    r.id_end  = e;
    r.last    = 1'b0;
    char_res.push_back(r);
  endtask

  task automatic lex_from_idle(input logic [7:0] c);
    lex_state = ltl_lex_pkg::M_IDLE;
    case (c)
      ltl_lex_pkg::CH_BANG: emit_tok(ltl_lex_pkg::TK_NEG, 8'h00, 1'b0);
      ltl_lex_pkg::CH_U:    emit_tok(ltl_lex_pkg::TK_UNTIL, 8'h00, 1'b0);
      ltl_lex_pkg::CH_V:    emit_tok(ltl_lex_pkg::TK_REL, 8'h00, 1'b0);
      ltl_lex_pkg::CH_X:    emit_tok(ltl_lex_pkg::TK_NEXT, 8'h00, 1'b0);
      ltl_lex_pkg::CH_LPAR: emit_tok(ltl_lex_pkg::TK_LPAR, 8'h00, 1'b0);
      ltl_lex_pkg::CH_RPAR: emit_tok(ltl_lex_pkg::TK_RPAR, 8'h00, 1'b0);
      ltl_lex_pkg::CH_NUL,
      ltl_lex_pkg::CH_HASH: emit_tok(ltl_lex_pkg::TK_END, 8'h00, 1'b0);
      ltl_lex_pkg::CH_LBRACE: begin
        emit_tok(ltl_lex_pkg::TK_ID, c, 1'b0);
        lex_state = ltl_lex_pkg::M_ID;
      end
      ltl_lex_pkg::CH_DASH: lex_state = ltl_lex_pkg::M_DASH;
      ltl_lex_pkg::CH_LT:   lex_state = ltl_lex_pkg::M_LT;
      ltl_lex_pkg::CH_AMP:  lex_state = ltl_lex_pkg::M_AMP;
      ltl_lex_pkg::CH_BAR:  lex_state = ltl_lex_pkg::M_BAR;
      ltl_lex_pkg::CH_LBRK: lex_state = ltl_lex_pkg::M_LBRK;
      default:              emit_tok(ltl_lex_pkg::TK_ERR, 8'h00, 1'b0);
    endcase
  endtask

  task automatic predict_tokens(input logic [7:0] c);
    int                n_err;
    int                i;
    ltl_lex_pkg::res_t r;
    n_err = 0;
    char_res.delete();
    case (lex_state)
      ltl_lex_pkg::M_IDLE: lex_from_idle(c);
      ltl_lex_pkg::M_DASH: begin
        if (c == ltl_lex_pkg::CH_GT) begin
          emit_tok(ltl_lex_pkg::TK_IMPL, 8'h00, 1'b0);
          lex_state = ltl_lex_pkg::M_IDLE;
        end else n_err = 1;
      end
      ltl_lex_pkg::M_LT: begin
        if (c == ltl_lex_pkg::CH_GT) begin
          emit_tok(ltl_lex_pkg::TK_EVE, 8'h00, 1'b0);
          lex_state = ltl_lex_pkg::M_IDLE;
        end else if (c == ltl_lex_pkg::CH_DASH) lex_state = ltl_lex_pkg::M_LTDASH;
        else n_err = 1;
      end
      ltl_lex_pkg::M_LTDASH: begin
        if (c == ltl_lex_pkg::CH_GT) begin
          emit_tok(ltl_lex_pkg::TK_EQU, 8'h00, 1'b0);
          lex_state = ltl_lex_pkg::M_IDLE;
        end else n_err = 2;
      end
      ltl_lex_pkg::M_AMP: begin
        if (c == ltl_lex_pkg::CH_AMP) begin
          emit_tok(ltl_lex_pkg::TK_AND, 8'h00, 1'b0);
          lex_state = ltl_lex_pkg::M_IDLE;
        end else n_err = 1;
      end
      ltl_lex_pkg::M_BAR: begin
        if (c == ltl_lex_pkg::CH_BAR) begin
          emit_tok(ltl_lex_pkg::TK_OR, 8'h00, 1'b0);
          lex_state = ltl_lex_pkg::M_IDLE;
        end else n_err = 1;
      end
      ltl_lex_pkg::M_LBRK: begin
        if (c == ltl_lex_pkg::CH_RBRK) begin
          emit_tok(ltl_lex_pkg::TK_ALW, 8'h00, 1'b0);
          lex_state = ltl_lex_pkg::M_IDLE;
        end else n_err = 1;
      end
      default: begin
        if (c == ltl_lex_pkg::CH_RBRACE) begin
          emit_tok(ltl_lex_pkg::TK_ID, c, 1'b1);
          lex_state = ltl_lex_pkg::M_IDLE;
        end else emit_tok(ltl_lex_pkg::TK_ID, c, 1'b0);
      end
    endcase
    // broken prefix: one error per pending char, then relex from idle
    if (n_err != 0) begin
      for (i = 0; i < n_err; i++) emit_tok(ltl_lex_pkg::TK_ERR, 8'h00, 1'b0);
      lex_from_idle(c);
    end
    for (i = 0; i < char_res.size(); i++) begin
      r = char_res[i];
      r.last = (i == char_res.size() - 1);
      tok_expect_q.push_back(r);
    end
  endtask

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    err_cnt++;
    $display("mismatch on %s at out beat %0d: got %0h, expected %0h",
             what, beats_seen, got, want);
  endtask

  // ---------------- character driver ----------------
  always @(posedge clk) begin : drv
    logic       nxt_valid;
    logic [7:0] nxt_data;
    int         pend;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        predict_tokens(in_tdata);
        chars_accepted++;
      end
      if (!in_tvalid || in_tready) begin
        nxt_valid = 1'b0;
        nxt_data  = in_tdata;
        if (gap_left > 0) begin
          gap_left--;
        end else if (char_q.size() != 0) begin
          if (char_q[0] == DRAIN_MARK) begin
            if (tok_expect_q.size() == 0) pend = char_q.pop_front();
          end else begin
            pend      = char_q.pop_front();
            nxt_data  = pend[7:0];
            nxt_valid = 1'b1;
            burst_left--;
            if (burst_left == 0) begin
              burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60)
                                                       : $urandom_range(1, 12);
              gap_left   = $urandom_range(1, 6);
            end
          end
        end
        in_tvalid <= nxt_valid;
        in_tdata  <= nxt_data;
      end
    end
  end

  // ---------------- token receiver ----------------
  always @(posedge clk) begin : rx
    logic rdy;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      rx_cycle++;
      if (!hold_done && chars_accepted >= HOLD_AT) begin
        hold_left = HOLD_LEN;
        hold_done = 1'b1;
      end
      case ((rx_cycle / 97) % 4)
        0:       rdy = 1'b1;
        1:       rdy = ($urandom_range(0, 1) == 1);
        2:       rdy = ((rx_cycle % 5) != 0);
        default: rdy = ($urandom_range(0, 3) == 0);
      endcase
      if (hold_left > 0) begin
        hold_left--;
        rdy = 1'b0;
      end
      out_tready <= rdy;
    end
  end

  // ---------------- token monitor ----------------
  always @(posedge clk) begin : mon
    ltl_lex_pkg::res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (tok_expect_q.size() == 0) begin
        report_mismatch("unexpected beat", out_tdata, 16'h0000);
      end else begin
        want = tok_expect_q.pop_front();
        if (out_tdata[3:0] !== want.token)
          report_mismatch("token", {12'h000, out_tdata[3:0]}, {12'h000, want.token});
        if (out_tdata[11:4] !== want.id_char)
          report_mismatch("id_char", {8'h00, out_tdata[11:4]}, {8'h00, want.id_char});
        if (out_tdata[15:12] !== 4'h0)
          report_mismatch("tdata pad", {12'h000, out_tdata[15:12]}, 16'h0000);
        if (out_tuser !== want.id_end)
          report_mismatch("id_end", {15'h0000, out_tuser}, {15'h0000, want.id_end});
        if (out_tlast !== want.last)
          report_mismatch("last", {15'h0000, out_tlast}, {15'h0000, want.last});
      end
      beats_seen++;
    end
  end

  // ---------------- stimulus ----------------
  task automatic add_char(input int c);
    char_q.push_back(c);
    n_chars++;
  endtask

  initial begin
    int  i;
    int  pick;
    int  c;
    bit  drain_put;
    drain_put = 1'b0;
    for (i = 0; i < NDIR; i++) add_char(dir_chars[i]);
    char_q.push_back(DRAIN_MARK);

    while (n_chars < NDIR + N_RANDOM) begin
      if (!drain_put && n_chars >= NDIR + N_RANDOM / 2) begin
        char_q.push_back(DRAIN_MARK);
        drain_put = 1'b1;
      end
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        case ($urandom_range(0, 11))
          0:  add_char(ltl_lex_pkg::CH_BANG);
          1:  add_char(ltl_lex_pkg::CH_U);
          2:  add_char(ltl_lex_pkg::CH_V);
          3:  add_char(ltl_lex_pkg::CH_X);
          4:  add_char(ltl_lex_pkg::CH_LPAR);
          5:  add_char(ltl_lex_pkg::CH_RPAR);
          6:  begin add_char(ltl_lex_pkg::CH_DASH); add_char(ltl_lex_pkg::CH_GT); end
          7:  begin
            add_char(ltl_lex_pkg::CH_LT);
            add_char(ltl_lex_pkg::CH_DASH);
            add_char(ltl_lex_pkg::CH_GT);
          end
          8:  begin add_char(ltl_lex_pkg::CH_LT); add_char(ltl_lex_pkg::CH_GT); end
          9:  begin add_char(ltl_lex_pkg::CH_AMP); add_char(ltl_lex_pkg::CH_AMP); end
          10: begin add_char(ltl_lex_pkg::CH_BAR); add_char(ltl_lex_pkg::CH_BAR); end
          default: begin add_char(ltl_lex_pkg::CH_LBRK); add_char(ltl_lex_pkg::CH_RBRK); end
        endcase
      end else if (pick < 60) begin
        add_char(ltl_lex_pkg::CH_LBRACE);
        repeat ($urandom_range(0, 6)) begin
          do c = $urandom_range(0, 255); while (c == ltl_lex_pkg::CH_RBRACE);
          add_char(c);
        end
        add_char(ltl_lex_pkg::CH_RBRACE);
      end else if (pick < 66) begin
        add_char(($urandom_range(0, 1) == 1) ? ltl_lex_pkg::CH_NUL : ltl_lex_pkg::CH_HASH);
      end else if (pick < 82) begin
        case ($urandom_range(0, 5))
          0: add_char(ltl_lex_pkg::CH_DASH);
          1: add_char(ltl_lex_pkg::CH_LT);
          2: begin add_char(ltl_lex_pkg::CH_LT); add_char(ltl_lex_pkg::CH_DASH); end
          3: add_char(ltl_lex_pkg::CH_AMP);
          4: add_char(ltl_lex_pkg::CH_BAR);
          default: add_char(ltl_lex_pkg::CH_LBRK);
        endcase
        add_char($urandom_range(0, 255));
      end else begin
        add_char($urandom_range(0, 255));
      end
    end

    while (chars_accepted < n_chars) @(posedge clk);
    while (tok_expect_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (err_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
